// ----- sv/b64sc_pkg.sv -----
package b64sc_pkg;

    // Mode register codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Register index of the mode register (paddr bit 2)
    localparam logic REG_MODE = 1'b0;

    // ASCII codes used by the codec
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_SLASH = 8'h2f;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PAD   = 8'h3d;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5a;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7a;

    // Command handed from the front end to the back end.
    // is_group: encode group of four characters; otherwise one result
    // whose byte sits in group[7:0].
    typedef struct packed {
        logic        is_group;
        logic [23:0] group;
        logic [1:0]  cnt;       // data characters minus one (encode)
        logic        fin;
        logic        has_data;
        logic        bad;
    } cmd_t;

    // 6-bit value of a base64 character; bit 6 set marks an illegal code
    function automatic logic [6:0] char_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
            d = c - CHAR_UC_A;
        end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
            d = c - CHAR_LC_A + 8'd26;
        end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO + 8'd52;
        end else if (c == CHAR_PLUS) begin
            d = 8'd62;
        end else if (c == CHAR_SLASH) begin
            d = 8'd63;
        end else begin
            d = 8'd64;
        end
        return d[6:0];
    endfunction

    // Standard alphabet character for a 6-bit value
    function automatic logic [7:0] alphabet_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (w < 8'd26) begin
            return CHAR_UC_A + w;
        end else if (w < 8'd52) begin
            return CHAR_LC_A + w - 8'd26;
        end else if (w < 8'd62) begin
            return CHAR_ZERO + w - 8'd52;
        end else if (w == 8'd62) begin
            return CHAR_PLUS;
        end else begin
            return CHAR_SLASH;
        end
    endfunction

endpackage

// ----- sv/b64sc_front.sv -----
module b64sc_front
    import b64sc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mode,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       last,
    output logic       cmd_valid,
    output cmd_t       cmd
);

    logic [15:0] held_bytes_reg, held_bytes_next;
    logic [1:0]  held_count_reg, held_count_next;
    logic [11:0] bit_buffer_reg, bit_buffer_next;
    logic [2:0]  bits_pending_reg, bits_pending_next;
    logic        stopped_reg, stopped_next;

    logic [2:0]  count;
    logic        skip;
    logic [6:0]  value;
    logic [11:0] acc;
    logic [3:0]  pend;
    logic [7:0]  dec_byte;

    // Classify the beat and update the per-mode message state
    always_comb
    begin
        held_bytes_next   = held_bytes_reg;
        held_count_next   = held_count_reg;
        bit_buffer_next   = bit_buffer_reg;
        bits_pending_next = bits_pending_reg;
        stopped_next      = stopped_reg;
        cmd_valid         = 1'b0;
        cmd               = '0;

        count = {1'b0, held_count_reg} + 3'd1;
        skip  = (in_byte >= CHAR_TAB && in_byte <= CHAR_CR) || in_byte == CHAR_SPACE
                || in_byte == CHAR_PAD;
        value = char_value(in_byte);
        acc   = {bit_buffer_reg[5:0], value[5:0]};
        pend  = {1'b0, bits_pending_reg} + 4'd6;

        // pend is 8, 10 or 12 when a byte is due
        case (pend[2:0])
            3'd0:    dec_byte = acc[7:0];
            3'd2:    dec_byte = acc[9:2];
            default: dec_byte = acc[11:4];
        endcase

        if (accept) begin
            if (mode == MODE_ENCODE) begin
                if (count < 3'd3 && !last) begin
                    if (held_count_reg == 2'd0) begin
                        held_bytes_next = {in_byte, 8'h00};
                    end else begin
                        held_bytes_next = {held_bytes_reg[15:8], in_byte};
                    end
                    held_count_next = count[1:0];
                end else begin
                    cmd_valid    = 1'b1;
                    cmd.is_group = 1'b1;
                    case (count)
                        3'd1:    cmd.group = {in_byte, 16'h0000};
                        3'd2:    cmd.group = {held_bytes_reg[15:8], in_byte, 8'h00};
                        default: cmd.group = {held_bytes_reg, in_byte};
                    endcase
                    cmd.cnt      = count[1:0];
                    cmd.fin      = last;
                    cmd.has_data = 1'b1;
                    held_bytes_next = '0;
                    held_count_next = '0;
                    if (last) begin
                        bit_buffer_next   = '0;
                        bits_pending_next = '0;
                        stopped_next      = 1'b0;
                    end
                end
            end else begin
                if (!stopped_reg && !skip) begin
                    if (value[6]) begin
                        stopped_next = 1'b1;
                    end else begin
                        if (pend[3]) begin
                            cmd_valid      = 1'b1;
                            cmd.group      = {16'h0000, dec_byte};
                            cmd.has_data   = 1'b1;
                            cmd.fin        = last;
                        end
                        bit_buffer_next   = acc;
                        bits_pending_next = pend[2:0];
                    end
                end
                if (last) begin
                    // silent end: empty end marker carries the error flag
                    if (!cmd_valid) begin
                        cmd_valid = 1'b1;
                        cmd.fin   = 1'b1;
                        cmd.bad   = stopped_next;
                    end
                    held_bytes_next   = '0;
                    held_count_next   = '0;
                    bit_buffer_next   = '0;
                    bits_pending_next = '0;
                    stopped_next      = 1'b0;
                end
            end
        end
    end

    // Message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_bytes_reg   <= '0;
            held_count_reg   <= '0;
            bit_buffer_reg   <= '0;
            bits_pending_reg <= '0;
            stopped_reg      <= 1'b0;
        end else begin
            held_bytes_reg   <= held_bytes_next;
            held_count_reg   <= held_count_next;
            bit_buffer_reg   <= bit_buffer_next;
            bits_pending_reg <= bits_pending_next;
            stopped_reg      <= stopped_next;
        end
    end

    // Encode never holds a full group between beats
    a_held_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != 2'd3)
        else $error("held_count reached three");

    // Decode pending bit count stays even
    a_pending_even: assert property (@(posedge clk) disable iff (!rst_n)
        !bits_pending_reg[0])
        else $error("odd bits_pending");

    // Every last beat produces a command
    a_last_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |-> (cmd_valid && cmd.fin))
        else $error("last beat without end command");

endmodule

// ----- sv/b64sc_fifo.sv -----
module b64sc_fifo
    import b64sc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic empty,
    output cmd_t head
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t            mem_reg [DEPTH];
    logic [IW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue underflow");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

// ----- sv/b64sc_back.sv -----
module b64sc_back
    import b64sc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  cmd_t       q_head,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       has_data,
    output logic       end_of_message,
    output logic       bad_input
);

    logic [1:0] k_reg, k_next;
    logic       out_valid_reg, out_valid_next;
    logic       load;
    logic       take;
    logic [5:0] sextet;
    logic [7:0] res_byte;
    logic       res_end;

    assign empty = !out_valid_reg;
    assign load  = !out_valid_reg || pop;
    assign take  = load && !q_empty;

    // Character select for the current beat of a group
    always_comb
    begin
        case (k_reg)
            2'd0:    sextet = q_head.group[23:18];
            2'd1:    sextet = q_head.group[17:12];
            2'd2:    sextet = q_head.group[11:6];
            default: sextet = q_head.group[5:0];
        endcase
        if (q_head.is_group) begin
            res_byte = (k_reg <= q_head.cnt) ? alphabet_char(sextet) : CHAR_PAD;
            res_end  = q_head.fin && (k_reg == 2'd3);
        end else begin
            res_byte = q_head.group[7:0];
            res_end  = q_head.fin;
        end
    end

    // Beat sequencing over the queue head
    always_comb
    begin
        k_next         = k_reg;
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = !q_empty;
        end
        if (take) begin
            if (!q_head.is_group || k_reg == 2'd3) begin
                q_pop  = 1'b1;
                k_next = 2'd0;
            end else begin
                k_next = k_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (take) begin
            out_byte       <= res_byte;
            has_data       <= q_head.has_data;
            end_of_message <= res_end;
            bad_input      <= q_head.bad;
        end
    end

    // Mid-group position only while a group heads the queue
    a_k_group: assert property (@(posedge clk) disable iff (!rst_n)
        (k_reg != 2'd0) |-> (!q_empty && q_head.is_group))
        else $error("group position without group at head");

    // A pending result is never dropped while stalled
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> out_valid_reg)
        else $error("result dropped under stall");

    // Group pops only on its fourth character
    a_group_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_head.is_group) |-> (k_reg == 2'd3))
        else $error("group popped early");

endmodule

// ----- sv/base64_stream_codec_unit.sv -----
// Streaming base64 codec. The mode register (address 0, bit 0) selects
// encode (0, bytes to standard-alphabet text with '=' padding) or liberal
// decode (1, text to bytes; whitespace and '=' are skipped, an illegal
// character is flagged on the message's end result). Items enter through a
// push/full queue port and results leave through an empty/pop queue port.
// The front end takes one item per cycle whenever its command queue
// (QUEUE_DEPTH entries) has room; the back end drives one result per cycle
// into the output register whenever that register is free or popped.
// Decoding thus sustains one item per cycle while results are popped;
// encoding is bounded by the single result port, since each group of three
// bytes, or a message's final partial group, yields four characters sent
// one at a time. An item's first result goes through the command queue,
// then the output register. Change mode only while the block is idle.
module base64_stream_codec_unit
    import b64sc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // item input
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        last,
    // result output
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        has_data,
    output logic        end_of_message,
    output logic        bad_input
);

    logic mode_reg, mode_next;
    logic accept;
    logic cmd_valid;
    cmd_t cmd;
    logic q_full, q_empty, q_pop;
    cmd_t q_head;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODE) ? {31'b0, mode_reg} : 32'b0;

    always_comb
    begin
        mode_next = mode_reg;
        if (psel && penable && pwrite && pready && paddr[2] == REG_MODE) begin
            mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_ENCODE;
        end else begin
            mode_reg <= mode_next;
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    b64sc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .accept    (accept),
        .in_byte   (in_byte),
        .last      (last),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    b64sc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_valid),
        .push_cmd (cmd),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    b64sc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .out_byte       (out_byte),
        .has_data       (has_data),
        .end_of_message (end_of_message),
        .bad_input      (bad_input)
    );

    // Error flag only ever rides on an end result
    a_bad_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && bad_input) |-> (end_of_message && !has_data))
        else $error("error flag outside empty end marker");

    // A result without data is always an end marker
    a_enc_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !has_data) |-> end_of_message)
        else $error("empty result that is not an end marker");

    // Items are never accepted into a full queue
    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !cmd_valid)
        else $error("command issued while queue full");

endmodule
